[design/mrp_pkg.sv]
// Shared types, codes and decode functions of the Modbus response PDU parser.
`timescale 1ns / 1ps

package mrp_pkg;

  // Result kinds, carried on tuser.
  localparam logic [1:0] RT_BIT    = 2'd0;
  localparam logic [1:0] RT_REG    = 2'd1;
  localparam logic [1:0] RT_STATUS = 2'd2;

  // Frame completion status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EXC    = 3'd1;
  localparam logic [2:0] ST_ODD    = 3'd2;
  localparam logic [2:0] ST_UNSUP  = 3'd3;
  localparam logic [2:0] ST_SHORT  = 3'd4;

  // Function code classes.
  localparam logic [1:0] KIND_BITS  = 2'd0;
  localparam logic [1:0] KIND_REGS  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_UNSUP = 2'd3;

  // Table codes.
  localparam logic [1:0] TBL_COILS    = 2'd0;
  localparam logic [1:0] TBL_DISCRETE = 2'd1;
  localparam logic [1:0] TBL_INPUT    = 2'd2;
  localparam logic [1:0] TBL_HOLDING  = 2'd3;

  // Function codes of interest.
  localparam logic [7:0] FC_RD_COILS    = 8'd1;
  localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
  localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT    = 8'd4;
  localparam logic [7:0] FC_WR_COIL     = 8'd5;
  localparam logic [7:0] FC_WR_REG      = 8'd6;
  localparam logic [7:0] FC_WR_COILS    = 8'd15;
  localparam logic [7:0] FC_WR_REGS     = 8'd16;
  localparam logic [7:0] FC_RW_REGS     = 8'd23;

  // Request queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_CODE    = 4'b0001,
    PH_COUNT   = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  // Work handed from the front to the back for one accepted byte.
  typedef struct packed {
    logic        emit_bits;    // eight bit results from value[7:0]
    logic        emit_reg;     // one register result
    logic        emit_status;  // completion result closes the frame
    logic [15:0] value;
    logic [10:0] index;
    logic [1:0]  tbl;
    logic [2:0]  status;
  } cmd_t;

  function automatic logic [1:0] code_kind(input logic [7:0] fc);
    logic [1:0] k;
    case (fc)
      FC_RD_COILS, FC_RD_DISCRETE:            k = KIND_BITS;
      FC_RD_HOLDING, FC_RD_INPUT, FC_RW_REGS: k = KIND_REGS;
      FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: k = KIND_WRITE;
      default:                                k = KIND_UNSUP;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] code_table(input logic [7:0] fc);
    logic [1:0] t;
    case ({1'b0, fc[6:0]})
      FC_RD_COILS, FC_WR_COIL, FC_WR_COILS:            t = TBL_COILS;
      FC_RD_DISCRETE:                                  t = TBL_DISCRETE;
      FC_RD_INPUT:                                     t = TBL_INPUT;
      FC_RD_HOLDING, FC_WR_REG, FC_WR_REGS, FC_RW_REGS: t = TBL_HOLDING;
      default:                                         t = TBL_COILS;
    endcase
    return t;
  endfunction

endpackage

[design/mrp_front.sv]
// Front end: accepts PDU bytes, tracks the frame and issues work requests.
`timescale 1ns / 1ps

module mrp_front import mrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       push,
  output cmd_t       push_cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] fc_r, fc_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [2:0] err_r, err_nxt;
  logic       accept;
  cmd_t       cmd;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    cnt_nxt   = cnt_r;
    seen_nxt  = seen_r;
    hold_nxt  = hold_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.tbl   = code_table(fc_r);
    if (accept) begin
      case (phase_r)
        PH_CODE: begin
          fc_nxt   = in_byte;
          cnt_nxt  = '0;
          seen_nxt = '0;
          hold_nxt = '0;
          cmd.tbl  = code_table(in_byte);
          if (in_byte[7]) begin
            err_nxt   = ST_EXC;
            phase_nxt = PH_DISCARD;
          end else begin
            case (code_kind(in_byte))
              KIND_BITS, KIND_REGS: begin
                err_nxt   = ST_OK;
                phase_nxt = PH_COUNT;
              end
              KIND_WRITE: begin
                err_nxt   = ST_OK;
                phase_nxt = PH_DISCARD;
              end
              default: begin
                err_nxt   = ST_UNSUP;
                phase_nxt = PH_DISCARD;
              end
            endcase
          end
        end
        PH_COUNT: begin
          cnt_nxt = in_byte;
          if ((code_kind(fc_r) == KIND_REGS) && in_byte[0]) begin
            err_nxt   = ST_ODD;
            phase_nxt = PH_DISCARD;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (seen_r < cnt_r) begin
            if (code_kind(fc_r) == KIND_BITS) begin
              cmd.emit_bits = 1'b1;
              cmd.value     = {8'd0, in_byte};
              cmd.index     = {seen_r, 3'd0};
            end else if (seen_r[0]) begin
              cmd.emit_reg = 1'b1;
              cmd.value    = {hold_r, in_byte};
              cmd.index    = {4'd0, seen_r[7:1]};
            end else begin
              hold_nxt = in_byte;
            end
            seen_nxt = seen_r + 8'd1;
          end
        end
        default: ;
      endcase
      if (in_end) begin
        // Close the frame: short if the count or data never fully arrived.
        cmd.emit_status = 1'b1;
        if ((phase_nxt == PH_COUNT) ||
            ((phase_nxt == PH_DATA) && (seen_nxt < cnt_nxt))) begin
          cmd.status = ST_SHORT;
        end else begin
          cmd.status = err_nxt;
        end
        phase_nxt = PH_CODE;
        fc_nxt    = '0;
        cnt_nxt   = '0;
        seen_nxt  = '0;
        hold_nxt  = '0;
        err_nxt   = ST_OK;
      end
    end
  end

  assign push     = accept && (cmd.emit_bits || cmd.emit_reg || cmd.emit_status);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      fc_r    <= '0;
      cnt_r   <= '0;
      seen_r  <= '0;
      hold_r  <= '0;
      err_r   <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      hold_r  <= hold_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[design/mrp_cmd_fifo.sv]
// Short request queue between the front end and the result serialiser.
`timescale 1ns / 1ps

module mrp_cmd_fifo import mrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic not_empty,
  output logic full
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[design/mrp_back.sv]
// Back end: expands queued requests into result items, one per cycle while the output is not stalled.
`timescale 1ns / 1ps

module mrp_back import mrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head_cmd,
  input  logic        not_empty,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic        valid_r, valid_nxt;
  logic [31:0] data_r, data_nxt;
  logic [1:0]  user_r, user_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic        vals_done_r, vals_done_nxt;
  logic        load, vals_pending;

  assign load         = not_empty && (!valid_r || out_tready);
  assign vals_pending = (head_cmd.emit_bits || head_cmd.emit_reg) && !vals_done_r;

  always_comb begin
    valid_nxt     = valid_r && !out_tready;
    data_nxt      = data_r;
    user_nxt      = user_r;
    last_nxt      = last_r;
    bit_idx_nxt   = bit_idx_r;
    vals_done_nxt = vals_done_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (vals_pending && head_cmd.emit_bits) begin
        user_nxt    = RT_BIT;
        last_nxt    = 1'b0;
        data_nxt    = {ST_OK, head_cmd.tbl, head_cmd.index[10:3], bit_idx_r,
                       15'd0, head_cmd.value[bit_idx_r]};
        bit_idx_nxt = bit_idx_r + 3'd1;
        if (bit_idx_r == 3'd7) begin
          if (head_cmd.emit_status) begin
            vals_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end else if (vals_pending) begin
        user_nxt = RT_REG;
        last_nxt = 1'b0;
        data_nxt = {ST_OK, head_cmd.tbl, head_cmd.index, head_cmd.value};
        if (head_cmd.emit_status) begin
          vals_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        user_nxt      = RT_STATUS;
        last_nxt      = 1'b1;
        data_nxt      = {head_cmd.status, head_cmd.tbl, 11'd0, 16'd0};
        vals_done_nxt = 1'b0;
        pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      bit_idx_r   <= '0;
      vals_done_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      bit_idx_r   <= bit_idx_nxt;
      vals_done_r <= vals_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

[design/modbus_response_pdu_parser_core.sv]
// Top level of the Modbus response PDU parser: front end, request queue, serialiser.
//
//  Channel | Dir | Handshake           | Payload
//  --------+-----+---------------------+--------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata[7:0] pdu_byte, tlast frame_end
//  out_    | out | out_tvalid/tready   | tuser result_type, tdata value/index/table/
//          |     |                     | status, tlast last
//
// A byte yields one request to the queue at most; its results pass through the
// queue and the output register. A coil or discrete-input data byte yields eight
// bit results in the serialiser (one bit result per cycle while the output is not
// stalled), then a completion result when it also ends the frame; any other
// byte's request yields one result, or two for a register byte ending the frame.
// rst_n is synchronous, active low; it returns the frame tracker to the
// function-code phase and empties the queue.
// A stalled result holds in the output register; the front keeps taking
// bytes until the queue fills, then every byte waits until a request leaves.
`timescale 1ns / 1ps

module modbus_response_pdu_parser_core import mrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pdu_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] value, [26:16] value_index,
                                  // [28:27] table_type, [31:29] status
  output logic [1:0]  out_tuser,  // [1:0] result_type
  output logic        out_tlast   // last
);

  logic push, pop, q_not_empty, q_full;
  cmd_t push_cmd, head_cmd;

  // Accept a byte whenever the queue has room for its request.
  assign in_tready = !q_full;

  mrp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mrp_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  mrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

[design/mrp_checker.sv]
// Port-level checks of the Modbus response PDU parser, bound to the top level.
`timescale 1ns / 1ps

module mrp_checker import mrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only a completion result ends a frame, and it always does.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == RT_STATUS)))
    else $error("tlast does not match completion result");

  // Value results carry ok status; bit results carry a single bit.
  a_value_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != RT_STATUS) |-> out_tdata[31:29] == ST_OK)
    else $error("value result with non-zero status");

  a_bit_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RT_BIT) |-> out_tdata[15:1] == 15'd0)
    else $error("bit result wider than one bit");

  // Completion results have zero value and index.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RT_STATUS) |-> out_tdata[26:0] == 27'd0)
    else $error("completion result with value or index set");

endmodule

bind modbus_response_pdu_parser_core mrp_checker u_mrp_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the Modbus response PDU parser core.
`timescale 1ns / 1ps

import mrp_pkg::*;

typedef struct {
  logic [1:0]  kind;
  logic [15:0] value;
  logic [10:0] index;
  logic [1:0]  tbl;
  logic [2:0]  status;
  logic        last;
} pdu_result_t;

class pdu_scoreboard;
  pdu_result_t pending_results[$];
  int          errors;

  // Frame tracker of the predictor.
  phase_t      phase;
  logic [7:0]  fc;
  logic [7:0]  byte_count;
  logic [7:0]  seen;
  logic [7:0]  hold;
  logic [2:0]  err;

  function new();
    errors = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    phase      = PH_CODE;
    fc         = '0;
    byte_count = '0;
    seen       = '0;
    hold       = '0;
    err        = ST_OK;
  endfunction

  function logic [1:0] code_family(input logic [7:0] c);
    if (c == FC_RD_COILS || c == FC_RD_DISCRETE) return KIND_BITS;
    if (c == FC_RD_HOLDING || c == FC_RD_INPUT || c == FC_RW_REGS) return KIND_REGS;
    if (c == FC_WR_COIL || c == FC_WR_REG || c == FC_WR_COILS || c == FC_WR_REGS)
      return KIND_WRITE;
    return KIND_UNSUP;
  endfunction

  // Table follows the code with the exception flag stripped.
  function logic [1:0] code_area(input logic [7:0] c);
    logic [7:0] base;
    base = {1'b0, c[6:0]};
    if (base == FC_RD_DISCRETE) return TBL_DISCRETE;
    if (base == FC_RD_INPUT) return TBL_INPUT;
    if (base == FC_RD_HOLDING || base == FC_WR_REG || base == FC_WR_REGS ||
        base == FC_RW_REGS) return TBL_HOLDING;
    return TBL_COILS;
  endfunction

  function void add_result(input logic [1:0] kind, input logic [15:0] value,
                           input logic [10:0] index, input logic [1:0] tbl,
                           input logic [2:0] status, input logic last);
    pdu_result_t r;
    r.kind   = kind;
    r.value  = value;
    r.index  = index;
    r.tbl    = tbl;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Advance the predictor by one accepted request byte.
  function void note_request(input logic [7:0] b, input logic frame_end);
    logic [1:0] tbl;
    logic [2:0] st;
    tbl = code_area(fc);
    case (phase)
      PH_CODE: begin
        fc         = b;
        byte_count = '0;
        seen       = '0;
        hold       = '0;
        tbl        = code_area(b);
        if (b[7]) begin
          err   = ST_EXC;
          phase = PH_DISCARD;
        end else begin
          case (code_family(b))
            KIND_BITS, KIND_REGS: begin
              err   = ST_OK;
              phase = PH_COUNT;
            end
            KIND_WRITE: begin
              err   = ST_OK;
              phase = PH_DISCARD;
            end
            default: begin
              err   = ST_UNSUP;
              phase = PH_DISCARD;
            end
          endcase
        end
      end
      PH_COUNT: begin
        byte_count = b;
        if (code_family(fc) == KIND_REGS && b[0]) begin
          err   = ST_ODD;
          phase = PH_DISCARD;
        end else begin
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (seen < byte_count) begin
          if (code_family(fc) == KIND_BITS) begin
            for (int j = 0; j < 8; j++)
              add_result(RT_BIT, {15'd0, b[j]}, {seen, 3'(j)}, tbl, ST_OK, 1'b0);
          end else if (seen[0]) begin
            add_result(RT_REG, {hold, b}, {4'd0, seen[7:1]}, tbl, ST_OK, 1'b0);
          end else begin
            hold = b;
          end
          seen = seen + 8'd1;
        end
      end
      default: ;
    endcase
    if (frame_end) begin
      st = err;
      if (phase == PH_COUNT || (phase == PH_DATA && seen < byte_count)) st = ST_SHORT;
      add_result(RT_STATUS, 16'd0, 11'd0, tbl, st, 1'b1);
      clear_frame();
    end
  endfunction

  function void flag_field(input string field, input logic [15:0] want,
                           input logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endfunction

  function void check_result(input pdu_result_t got);
    pdu_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got type %0h value %0h index %0h",
               $time, got.kind, got.value, got.index);
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind) flag_field("result_type", want.kind, got.kind);
    if (got.value !== want.value) flag_field("value", want.value, got.value);
    if (got.index !== want.index) flag_field("value_index", want.index, got.index);
    if (got.tbl !== want.tbl) flag_field("table_type", want.tbl, got.tbl);
    if (got.status !== want.status) flag_field("status", want.status, got.status);
    if (got.last !== want.last) flag_field("last", want.last, got.last);
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 120;
  localparam int CALM_AFTER  = 90;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  pdu_scoreboard sb;
  int            cycles;
  int            n_sent;
  int            in_gap_pct;
  bit            calm;

  modbus_response_pdu_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** modbus_response_pdu_parser_core: FAILED **");
      $finish;
    end
  end

  // Monitors sample both channels at the edge, before any update lands.
  always @(posedge clk) begin
    pdu_result_t got;
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.value  = out_tdata[15:0];
      got.index  = out_tdata[26:16];
      got.tbl    = out_tdata[28:27];
      got.status = out_tdata[31:29];
      got.last   = out_tlast;
      sb.check_result(got);
    end
  end

  // Result side: stall in bursts until the calm tail of the run.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic frame_end);
    if (!calm && in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Build one frame: mostly well-formed reads, with writes, exceptions,
  // unknown codes, odd counts, short and over-long frames mixed in.
  task automatic random_frame();
    logic [7:0] fr[$];
    logic [7:0] code;
    logic [7:0] cnt;
    int         pick;
    int         n_data;
    int         n_extra;
    bit         reg_read;
    in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      code = ($urandom_range(0, 1) != 0) ? FC_RD_DISCRETE : FC_RD_COILS;
    end else if (pick < 60) begin
      case ($urandom_range(0, 2))
        0:       code = FC_RD_HOLDING;
        1:       code = FC_RD_INPUT;
        default: code = FC_RW_REGS;
      endcase
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       code = FC_WR_COIL;
        1:       code = FC_WR_REG;
        2:       code = FC_WR_COILS;
        default: code = FC_WR_REGS;
      endcase
    end else if (pick < 84) begin
      code = {1'b1, 7'($urandom_range(0, 127))};
    end else begin
      code = 8'($urandom_range(0, 255));
    end
    fr.push_back(code);
    if (code inside {FC_RD_COILS, FC_RD_DISCRETE, FC_RD_HOLDING, FC_RD_INPUT,
                     FC_RW_REGS}) begin
      reg_read = !(code inside {FC_RD_COILS, FC_RD_DISCRETE});
      pick = $urandom_range(0, 99);
      if (pick >= 4) begin
        cnt = (pick < 10) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
        if (reg_read && pick >= 16) cnt[0] = 1'b0;
        fr.push_back(cnt);
        n_data  = cnt;
        n_extra = 0;
        pick = $urandom_range(0, 99);
        if (n_data > 8 || pick < 10)
          n_data = $urandom_range(0, (n_data > 8) ? 8 : n_data);
        else if (pick < 20)
          n_extra = $urandom_range(1, 2);
        repeat (n_data) fr.push_back(8'($urandom_range(0, 255)));
        repeat (n_extra) fr.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 3)) fr.push_back(8'($urandom_range(0, 255)));
    end
    n_sent += fr.size();
    send_frame(fr);
    if (n_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  initial begin
    sb         = new();
    cycles     = 0;
    n_sent     = 0;
    in_gap_pct = 0;
    calm       = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, one per special case.
    send_frame('{FC_RD_COILS, 8'd1, 8'hA5});                  // one coil byte
    send_frame('{FC_RD_DISCRETE, 8'd0});                      // zero byte count
    send_frame('{FC_RD_HOLDING, 8'd3});                       // odd register count
    send_frame('{FC_RD_INPUT, 8'd2, 8'hFF, 8'h00});           // one register
    send_frame('{FC_RW_REGS, 8'd4, 8'h12, 8'h34, 8'h56});     // short, lone high byte
    send_frame('{FC_WR_COIL});                                // write echo
    send_frame('{8'h83, 8'd2});                               // exception
    send_frame('{8'h07});                                     // unknown code
    send_frame('{FC_RD_COILS});                               // ends before count
    send_frame('{FC_RD_COILS, 8'd1, 8'h5A, 8'h00});           // extra data byte
    n_sent = 25;

    while (n_sent < ITEM_TARGET) random_frame();
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** modbus_response_pdu_parser_core: PASSED **");
    end else begin
      $display("** modbus_response_pdu_parser_core: FAILED **");
    end
    $finish;
  end
endmodule

[sim.f]
design/mrp_pkg.sv
design/mrp_front.sv
design/mrp_cmd_fifo.sv
design/mrp_back.sv
design/modbus_response_pdu_parser_core.sv
design/mrp_checker.sv
dv/tb_top.sv
